FILE: design/slmc_pkg.sv
package slmc_pkg;

    // Mode codes
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_POST = 2'd2;
    localparam logic [1:0] MODE_ERR  = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] REG_POST_PERIOD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ERR_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ERR_TOTAL   = 2'd2;

    // Configuration reset values
    localparam logic [CFG_DATA_BITS-1:0] RST_POST_PERIOD = 16'd250;
    localparam logic [CFG_DATA_BITS-1:0] RST_ERR_PERIOD  = 16'd100;
    localparam logic [CFG_DATA_BITS-1:0] RST_ERR_TOTAL   = 16'd5000;

    // Mode, LED level and last sampled link status
    typedef struct packed {
        logic [1:0] mode;
        logic       led;
        logic       link_prev;
    } t_ctl;

endpackage

FILE: design/slmc_if.sv
interface slmc_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [1:0] new_mode;
    logic       link_up;

    modport source (output valid, output cmd, output new_mode, output link_up, input ready);
    modport sink   (input valid, input cmd, input new_mode, input link_up, output ready);
endinterface

interface slmc_out_if;
    logic       valid;
    logic       ready;
    logic       led_on;
    logic [1:0] mode_now;

    modport source (output valid, output led_on, output mode_now, input ready);
    modport sink   (input valid, input led_on, input mode_now, output ready);
endinterface

interface slmc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [slmc_pkg::CFG_IDX_BITS-1:0]  index;
    logic [slmc_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/slmc_step.sv
module slmc_step #(
    parameter int TIMER_BITS = 16
) (
    input  slmc_pkg::t_ctl                     i_ctl,
    input  logic                               i_cmd,
    input  logic [1:0]                         i_new_mode,
    input  logic                               i_link_up,
    input  logic [TIMER_BITS-1:0]              i_since_toggle,
    input  logic [TIMER_BITS-1:0]              i_since_err,
    input  logic [slmc_pkg::CFG_DATA_BITS-1:0] i_post_period,
    input  logic [slmc_pkg::CFG_DATA_BITS-1:0] i_err_period,
    input  logic [slmc_pkg::CFG_DATA_BITS-1:0] i_err_total,
    output slmc_pkg::t_ctl                     o_ctl,
    output logic [TIMER_BITS-1:0]              o_since_toggle,
    output logic [TIMER_BITS-1:0]              o_since_err
);

    // Compare width covers both the timers and the 16-bit registers
    localparam int CMP_BITS = (TIMER_BITS > slmc_pkg::CFG_DATA_BITS) ?
                              TIMER_BITS : slmc_pkg::CFG_DATA_BITS;

    logic [TIMER_BITS-1:0] st_inc;
    logic [TIMER_BITS-1:0] se_inc;
    logic                  post_due;
    logic                  blink_due;
    logic                  err_done;

    // Saturating advance of both elapsed counters
    assign st_inc = (&i_since_toggle) ? i_since_toggle : i_since_toggle + TIMER_BITS'(1);
    assign se_inc = (&i_since_err) ? i_since_err : i_since_err + TIMER_BITS'(1);

    assign post_due  = CMP_BITS'(st_inc) >= CMP_BITS'(i_post_period);
    assign blink_due = CMP_BITS'(st_inc) >= CMP_BITS'(i_err_period);
    assign err_done  = CMP_BITS'(se_inc) >= CMP_BITS'(i_err_total);

    always_comb begin
        o_ctl           = i_ctl;
        o_since_toggle  = st_inc;
        o_since_err     = se_inc;
        o_ctl.link_prev = i_link_up;
        if (i_cmd) begin
            // Load the requested mode and restart the timers
            o_ctl.link_prev = i_ctl.link_prev;
            o_ctl.mode      = i_new_mode;
            o_ctl.led       = (i_new_mode == slmc_pkg::MODE_ON);
            o_since_toggle  = '0;
            o_since_err     = '0;
        end else if (!i_link_up) begin
            // Link down: drop to off
            if (i_ctl.mode != slmc_pkg::MODE_OFF) begin
                o_ctl.mode     = slmc_pkg::MODE_OFF;
                o_ctl.led      = 1'b0;
                o_since_toggle = '0;
                o_since_err    = '0;
            end
        end else if (!i_ctl.link_prev && i_ctl.mode == slmc_pkg::MODE_OFF) begin
            // Rising link edge lifts off to on
            o_ctl.mode     = slmc_pkg::MODE_ON;
            o_ctl.led      = 1'b1;
            o_since_toggle = '0;
            o_since_err    = '0;
        end else begin
            unique case (i_ctl.mode)
                slmc_pkg::MODE_POST: begin
                    if (post_due) begin
                        o_since_toggle = '0;
                        o_ctl.led      = ~i_ctl.led;
                    end
                end
                slmc_pkg::MODE_ERR: begin
                    if (blink_due) begin
                        o_since_toggle = '0;
                        o_ctl.led      = ~i_ctl.led;
                    end
                    // Error time spent: settle on steady on
                    if (err_done) begin
                        o_ctl.mode     = slmc_pkg::MODE_ON;
                        o_ctl.led      = 1'b1;
                        o_since_toggle = '0;
                        o_since_err    = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: design/status_led_mode_controller.sv
// Channel  Dir  Handshake      Payload
// i_in     in   valid/ready    cmd, new_mode, link_up
// o_out    out  valid/ready    led_on, mode_now
// i_cfg    in   valid/ready    index, data (ready always high)
//
// Every request yields one result, registered first in the input register
// and then in the result register around the combinational mode update; one
// request is taken each cycle while the result is not stalled.
// Reset (synchronous, active low) sets mode off, LED dark, timers zero and
// the registers to 250 / 100 / 5000.
// A stalled result holds the update stage; the input register then fills
// and i_in.ready falls.
module status_led_mode_controller #(
    parameter int TIMER_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    slmc_in_if.sink          i_in,
    slmc_out_if.source       o_out,
    slmc_cfg_if.sink         i_cfg
);

    logic                               r_s1_valid;
    logic                               r_s1_cmd;
    logic [1:0]                         r_s1_new_mode;
    logic                               r_s1_link_up;
    logic                               r_out_valid;
    logic                               r_out_led;
    logic [1:0]                         r_out_mode;
    slmc_pkg::t_ctl                     r_ctl;
    slmc_pkg::t_ctl                     n_ctl;
    logic [TIMER_BITS-1:0]              r_since_toggle;
    logic [TIMER_BITS-1:0]              n_since_toggle;
    logic [TIMER_BITS-1:0]              r_since_err;
    logic [TIMER_BITS-1:0]              n_since_err;
    logic [slmc_pkg::CFG_DATA_BITS-1:0] r_post_period;
    logic [slmc_pkg::CFG_DATA_BITS-1:0] r_err_period;
    logic [slmc_pkg::CFG_DATA_BITS-1:0] r_err_total;
    logic                               out_free;
    logic                               s1_go;
    logic                               in_take;

    // Handshake control
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_go      = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_take    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cmd      <= i_in.cmd;
            r_s1_new_mode <= i_in.new_mode;
            r_s1_link_up  <= i_in.link_up;
        end
    end

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_post_period <= slmc_pkg::RST_POST_PERIOD;
            r_err_period  <= slmc_pkg::RST_ERR_PERIOD;
            r_err_total   <= slmc_pkg::RST_ERR_TOTAL;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                slmc_pkg::REG_POST_PERIOD: r_post_period <= i_cfg.data;
                slmc_pkg::REG_ERR_PERIOD:  r_err_period  <= i_cfg.data;
                slmc_pkg::REG_ERR_TOTAL:   r_err_total   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Mode update
    slmc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_ctl          (r_ctl),
        .i_cmd          (r_s1_cmd),
        .i_new_mode     (r_s1_new_mode),
        .i_link_up      (r_s1_link_up),
        .i_since_toggle (r_since_toggle),
        .i_since_err    (r_since_err),
        .i_post_period  (r_post_period),
        .i_err_period   (r_err_period),
        .i_err_total    (r_err_total),
        .o_ctl          (n_ctl),
        .o_since_toggle (n_since_toggle),
        .o_since_err    (n_since_err)
    );

    // Advance state as the request leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl          <= '0;
            r_since_toggle <= '0;
            r_since_err    <= '0;
        end else if (s1_go) begin
            r_ctl          <= n_ctl;
            r_since_toggle <= n_since_toggle;
            r_since_err    <= n_since_err;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_led  <= n_ctl.led;
            r_out_mode <= n_ctl.mode;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.led_on   = r_out_led;
    assign o_out.mode_now = r_out_mode;

endmodule

FILE: design/slmc_checker.sv
module slmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_cmd,
    input logic [1:0] i_in_new_mode,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_led_on,
    input logic [1:0] i_out_mode_now
);

    // Steady modes fix the LED level
    a_mode_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_mode_now == slmc_pkg::MODE_ON && i_out_led_on) ||
                         (i_out_mode_now == slmc_pkg::MODE_OFF && !i_out_led_on) ||
                         i_out_mode_now == slmc_pkg::MODE_POST ||
                         i_out_mode_now == slmc_pkg::MODE_ERR))
        else $error("LED level disagrees with steady mode");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_led_on) && $stable(i_out_mode_now)))
        else $error("stalled result changed");

    // A set-mode request shows its mode, via the input and result registers, when the output moves
    a_set_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_cmd) ##1 (!i_out_valid || i_out_ready) |=>
            (i_out_valid && i_out_mode_now == $past(i_in_new_mode, 2)))
        else $error("set-mode result missing or wrong");

    // Reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind status_led_mode_controller slmc_checker u_slmc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_cmd       (i_in.cmd),
    .i_in_new_mode  (i_in.new_mode),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_led_on   (o_out.led_on),
    .i_out_mode_now (o_out.mode_now)
);
